@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be seen.
`define BBO_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Flag a consequent that must hold in the cycle after its antecedent.
`define BBO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bbo_pkg.sv @@
package bbo_pkg;

	// Configuration port
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_BEAT_INCREMENT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GLIDE_COEFFICIENT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RATE_SCALE        = 2'd2;

	localparam int unsigned BEAT_W  = 32;
	localparam int unsigned GLIDE_W = 17;
	localparam int unsigned RATE_W  = 20;

	localparam logic [BEAT_W-1:0]  BEAT_RESET  = 32'd357913;
	localparam logic [GLIDE_W-1:0] GLIDE_RESET = 17'd105;
	localparam logic [GLIDE_W-1:0] GLIDE_MAX   = 17'd65536;
	localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd89478;

	// MIDI
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] NO_NOTE         = 8'hFF;

	// Datapath widths
	localparam int unsigned FREQ_W     = 30;
	localparam int unsigned LEVEL_W    = 16;
	localparam int unsigned INC_W      = 32;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned SINE_MAG_W = 15;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Semitones of notes 120..131 in unsigned Q14.16 hertz
	localparam int unsigned TOP_OCTAVE_NUM = 10;
	localparam logic [FREQ_W-1:0] TOP_OCTAVE [12] = '{
		30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
		30'd691279090, 30'd732384684, 30'd775934544, 30'd822074012,
		30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
	};

	typedef enum logic [1:0] {
		OP_TICK,
		OP_NOTE_ON,
		OP_NOTE_OFF
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [6:0]         note;
		logic [FREQ_W-1:0]  freq;
		logic [LEVEL_W-1:0] level;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NOTE_SET,
		ST_GLIDE_LVL,
		ST_PHASE,
		ST_ROM_L,
		ST_ROM_R,
		ST_SCALE_R,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MUL_FREQ,
		MUL_INC,
		MUL_LVL,
		MUL_SMP
	} mul_sel_t;

	typedef struct packed {
		logic     pop;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     note_set;
		logic     note_off;
		logic     inc_upd;
		logic     lvl_upd;
		logic     phase_upd;
		logic     rom_en;
		logic     rom_right;
		logic     left_cap;
		logic     emit;
	} ctl_t;

endpackage

@@ rtl/bbo_front.sv @@
module bbo_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic          func,
	input  logic [7:0]    status,
	input  logic [6:0]    data_one,
	input  logic [6:0]    data_two,
	output logic          push_valid,
	input  logic          push_ready,
	output bbo_pkg::cmd_t push_cmd
);
	import bbo_pkg::*;

	typedef logic [FREQ_W-1:0]  freq_rom_t  [128];
	typedef logic [LEVEL_W-1:0] level_rom_t [128];

	// Note frequency: semitone of the top octave shifted down by octave distance
	function automatic freq_rom_t build_freq_rom();
		freq_rom_t r;
		for (int n = 0; n < 128; n++) begin
			r[n] = TOP_OCTAVE[n % 12] >> (TOP_OCTAVE_NUM - (n / 12));
		end
		return r;
	endfunction

	// Level in Q1.15 from velocity, rounded
	function automatic level_rom_t build_level_rom();
		level_rom_t r;
		for (int v = 0; v < 128; v++) begin
			r[v] = LEVEL_W'((v * 32768 + 63) / 127);
		end
		return r;
	endfunction

	localparam freq_rom_t  FREQ_ROM  = build_freq_rom();
	localparam level_rom_t LEVEL_ROM = build_level_rom();

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic keep;

	// Classify the beat; drop statuses that do nothing
	always_comb begin
		keep       = 1'b0;
		cmd_d.op    = OP_TICK;
		cmd_d.note  = data_one;
		cmd_d.freq  = FREQ_ROM[data_one];
		cmd_d.level = LEVEL_ROM[data_two];
		if (!func) begin
			keep = 1'b1;
		end else if (status == STATUS_NOTE_ON) begin
			keep     = 1'b1;
			cmd_d.op = OP_NOTE_ON;
		end else if (status == STATUS_NOTE_OFF) begin
			keep     = 1'b1;
			cmd_d.op = OP_NOTE_OFF;
		end
	end

	assign item_ready = !valid_s1 || push_ready;

	// Hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

@@ rtl/bbo_queue.sv @@
module bbo_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bbo_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output bbo_pkg::cmd_t pop_cmd
);
	import bbo_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/bbo_back.sv @@
module bbo_back #(
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned PHASE_BITS      = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bbo_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bbo_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                pop_valid,
	output logic                                pop,
	input  bbo_pkg::cmd_t                       pop_cmd,
	output logic                                sample_valid,
	input  logic                                sample_ready,
	output logic signed [bbo_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [bbo_pkg::SAMPLE_W-1:0] right_sample
);
	import bbo_pkg::*;

	localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
	localparam int unsigned ROM_AW = SINE_TABLE_BITS + 1;

	typedef logic [SINE_MAG_W-1:0] sine_rom_t [SINE_N + 1];

	// Quarter-wave sine magnitude by a Q30 odd polynomial
	function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] y;
		x  = 64'(i) << (30 - SINE_TABLE_BITS);
		x2 = (x * x) >> 30;
		t  = 64'd5026995 - ((x2 * 64'd172273) >> 30);
		t  = 64'd85569306 - ((x2 * t) >> 30);
		t  = 64'd693598668 - ((x2 * t) >> 30);
		t  = 64'd1686629713 - ((x2 * t) >> 30);
		y  = (x * t) >> 30;
		y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
		if (y > 64'd32767) begin
			y = 64'd32767;
		end
		return y[SINE_MAG_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int i = 0; i <= int'(SINE_N); i++) begin
			r[i] = quarter_sine(i);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	state_t state_q;
	state_t state_d;
	ctl_t   ctl;

	logic [BEAT_W-1:0]     beat_q;
	logic [GLIDE_W-1:0]    glide_q;
	logic [RATE_W-1:0]     rate_q;
	logic [PHASE_BITS-1:0] phase_l_q;
	logic [PHASE_BITS-1:0] phase_r_q;
	logic [INC_W-1:0]      inc_now_q;
	logic [INC_W-1:0]      inc_tgt_q;
	logic [LEVEL_W-1:0]    lvl_now_q;
	logic [LEVEL_W-1:0]    lvl_tgt_q;
	logic [7:0]            held_q;

	logic signed [33:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [54:0] prod_d;
	logic signed [54:0] prod_q;
	logic signed [54:0] rnd;
	logic [32:0]        diff_inc;
	logic [16:0]        diff_lvl;
	logic [SAMPLE_W-1:0] mag16;
	logic [SAMPLE_W-1:0] smp;
	logic [50:0]         inc_sum;
	logic [INC_W-1:0]    inc_sat;
	logic [INC_W-1:0]    inc_beat;

	logic [PHASE_BITS-1:0]      rom_phase;
	logic [1:0]                 quad;
	logic [SINE_TABLE_BITS-1:0] off;
	logic [ROM_AW-1:0]          rom_addr;
	logic [SINE_MAG_W-1:0]      rom_q;
	logic                       neg_q;

	logic [SAMPLE_W-1:0] left_hold_q;
	logic [SAMPLE_W-1:0] left_q;
	logic [SAMPLE_W-1:0] right_q;
	logic                sample_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					case (pop_cmd.op)
						OP_NOTE_ON: state_d = ST_NOTE_SET;
						OP_TICK:    state_d = ST_GLIDE_LVL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_NOTE_SET:  state_d = ST_IDLE;
			ST_GLIDE_LVL: state_d = ST_PHASE;
			ST_PHASE:     state_d = ST_ROM_L;
			ST_ROM_L:     state_d = ST_ROM_R;
			ST_ROM_R:     state_d = ST_SCALE_R;
			ST_SCALE_R:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (!sample_valid_q || sample_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control strobes
	always_comb begin
		ctl         = '0;
		ctl.mul_sel = MUL_FREQ;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					case (pop_cmd.op)
						OP_NOTE_ON: begin
							ctl.mul_en  = 1'b1;
							ctl.mul_sel = MUL_FREQ;
						end
						OP_TICK: begin
							ctl.mul_en  = 1'b1;
							ctl.mul_sel = MUL_INC;
						end
						OP_NOTE_OFF: begin
							ctl.note_off = 1'b1;
							ctl.pop      = 1'b1;
						end
						default: ctl.pop = 1'b1;
					endcase
				end
			end
			ST_NOTE_SET: begin
				ctl.note_set = 1'b1;
				ctl.pop      = 1'b1;
			end
			ST_GLIDE_LVL: begin
				ctl.inc_upd = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_LVL;
			end
			ST_PHASE: begin
				ctl.lvl_upd   = 1'b1;
				ctl.phase_upd = 1'b1;
			end
			ST_ROM_L: ctl.rom_en = 1'b1;
			ST_ROM_R: begin
				ctl.rom_en    = 1'b1;
				ctl.rom_right = 1'b1;
				ctl.mul_en    = 1'b1;
				ctl.mul_sel   = MUL_SMP;
			end
			ST_SCALE_R: begin
				ctl.left_cap = 1'b1;
				ctl.mul_en   = 1'b1;
				ctl.mul_sel  = MUL_SMP;
			end
			ST_EMIT: begin
				if (!sample_valid_q || sample_ready) begin
					ctl.emit = 1'b1;
					ctl.pop  = 1'b1;
				end
			end
			default: ctl = '0;
		endcase
	end

	assign pop = ctl.pop;

	// Shared multiplier operands
	assign diff_inc = {1'b0, inc_tgt_q} - {1'b0, inc_now_q};
	assign diff_lvl = {1'b0, lvl_tgt_q} - {1'b0, lvl_now_q};
	assign mag16    = {1'b0, rom_q};
	assign smp      = neg_q ? (~mag16 + 16'd1) : mag16;

	always_comb begin
		case (ctl.mul_sel)
			MUL_FREQ: begin
				mul_a = {4'b0, pop_cmd.freq};
				mul_b = {1'b0, rate_q};
			end
			MUL_INC: begin
				mul_a = {diff_inc[32], diff_inc};
				mul_b = {4'b0, glide_q};
			end
			MUL_LVL: begin
				mul_a = {{17{diff_lvl[16]}}, diff_lvl};
				mul_b = {4'b0, glide_q};
			end
			MUL_SMP: begin
				mul_a = {{18{smp[15]}}, smp};
				mul_b = {5'b0, lvl_now_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Round the scaled sample half up
	assign rnd = prod_q + 55'sd16384;

	// Increment from frequency, saturated at full scale
	assign inc_sum  = {1'b0, prod_q[49:0]} + 51'd32768;
	assign inc_sat  = (|inc_sum[50:48]) ? '1 : inc_sum[47:16];
	assign inc_beat = inc_now_q + beat_q;

	// Sine ROM address: mirror falling quadrants
	assign rom_phase = ctl.rom_right ? phase_r_q : phase_l_q;
	assign quad      = rom_phase[PHASE_BITS-1 -: 2];
	assign off       = rom_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign rom_addr  = quad[0] ? (ROM_AW'(SINE_N) - {1'b0, off}) : {1'b0, off};

	// State, configuration, note, glide, level and phase registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			beat_q         <= BEAT_RESET;
			glide_q        <= GLIDE_RESET;
			rate_q         <= RATE_RESET;
			phase_l_q      <= '0;
			phase_r_q      <= '0;
			inc_now_q      <= '0;
			inc_tgt_q      <= '0;
			lvl_now_q      <= '0;
			lvl_tgt_q      <= '0;
			held_q         <= NO_NOTE;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					REG_BEAT_INCREMENT:    beat_q  <= cfg_data[BEAT_W-1:0];
					REG_GLIDE_COEFFICIENT: glide_q <= cfg_data[16] ? GLIDE_MAX
					                                              : cfg_data[GLIDE_W-1:0];
					REG_RATE_SCALE:        rate_q  <= cfg_data[RATE_W-1:0];
					default:               beat_q  <= beat_q;
				endcase
			end
			if (ctl.note_set) begin
				inc_tgt_q <= inc_sat;
				lvl_tgt_q <= pop_cmd.level;
				held_q    <= {1'b0, pop_cmd.note};
			end
			if (ctl.note_off && ({1'b0, pop_cmd.note} == held_q)) begin
				lvl_tgt_q <= '0;
			end
			if (ctl.inc_upd) begin
				inc_now_q <= inc_now_q + prod_q[47:16];
			end
			if (ctl.lvl_upd) begin
				lvl_now_q <= lvl_now_q + prod_q[31:16];
			end
			if (ctl.phase_upd) begin
				phase_l_q <= phase_l_q + inc_now_q[INC_W-1 -: PHASE_BITS];
				phase_r_q <= phase_r_q + inc_beat[INC_W-1 -: PHASE_BITS];
			end
			if (ctl.emit) begin
				sample_valid_q <= 1'b1;
			end else if (sample_ready) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	// Product, ROM read and sample registers
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.rom_en) begin
			rom_q <= SINE_ROM[rom_addr];
			neg_q <= quad[1];
		end
		if (ctl.left_cap) begin
			left_hold_q <= rnd[30:15];
		end
		if (ctl.emit) begin
			left_q  <= left_hold_q;
			right_q <= rnd[30:15];
		end
	end

	assign sample_valid = sample_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

endmodule

@@ rtl/binaural_beat_oscillator_unit.sv @@
// Binaural beat oscillator.
// Item channel (item_valid/item_ready) takes one beat per MIDI message or sample
// tick: func 0 is a tick, func 1 a MIDI message in status, data_one, data_two.
// Note-on (0x90) and note-off (0x80) on channel 0 act; other messages are dropped
// at the front. Every tick yields one beat on the sample channel
// (sample_valid/sample_ready) with left_sample and right_sample in Q1.15.
// The front registers and classifies a beat, a two-entry queue decouples it from
// the back end, which runs one command at a time on a shared 34x21 multiplier and
// a single-port quarter-wave sine ROM. A tick steps through idle, glide/level,
// phase, left and right ROM reads, right scaling and emit, which waits while the
// receiver stalls; a note-on through idle and note set; a note-off ends in idle.
// The sample output is a register: while the receiver stalls the front keeps
// taking beats until the queue fills, then item_ready drops.
// cfg_write/cfg_index/cfg_data write beat_increment, glide_coefficient and
// rate_scale; write them only while the block is idle.
// Reset clears phases, increments and levels, forgets the held note and restores
// the register defaults; the block takes items as soon as reset is released.
module binaural_beat_oscillator_unit #(
	parameter int unsigned SINE_TABLE_BITS = 10,
	parameter int unsigned PHASE_BITS      = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [bbo_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bbo_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                func,
	input  logic [7:0]                          status,
	input  logic [6:0]                          data_one,
	input  logic [6:0]                          data_two,
	output logic                                sample_valid,
	input  logic                                sample_ready,
	output logic signed [bbo_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [bbo_pkg::SAMPLE_W-1:0] right_sample
);
	import bbo_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	cmd_t pop_cmd;

	bbo_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (func),
		.status     (status),
		.data_one   (data_one),
		.data_two   (data_two),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	bbo_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	bbo_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.PHASE_BITS      (PHASE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_cmd      (pop_cmd),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule

@@ rtl/bbo_checker.sv @@
`include "assert_macros.svh"

module bbo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_ready,
	input logic [15:0] left_sample,
	input logic [15:0] right_sample
);

	// Hold a stalled sample beat
	`BBO_ASSERT_NEXT(a_valid_hold, clk, arst_n, sample_valid && !sample_ready, sample_valid, "sample beat dropped while stalled")
	`BBO_ASSERT_NEXT(a_data_hold, clk, arst_n, sample_valid && !sample_ready, $stable(left_sample) && $stable(right_sample), "sample beat changed while stalled")

	// Full-scale sine times unity level stays above negative full scale
	`BBO_ASSERT_NEVER(a_left_range, clk, arst_n, sample_valid && (left_sample == 16'h8000), "left sample out of range")
	`BBO_ASSERT_NEVER(a_right_range, clk, arst_n, sample_valid && (right_sample == 16'h8000), "right sample out of range")

endmodule

bind binaural_beat_oscillator_unit bbo_checker u_bbo_checker (.*);
